// ===== rtl/bae_pkg.sv =====
// Shared types and constants for the binary arithmetic encoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bae_pkg;

	// Fixed widths of the channel fields
	localparam int FIELD_W      = 16;
	localparam int FOLLOW_W     = 16;

	// Defaults for the top-level parameters
	localparam int PRECISION_DEF = 32;
	localparam int COUNT_DEF     = 16;
	localparam int PENDING_DEF   = 16;

	// Input command codes
	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;        // capture the accepted input word
		logic mul_hi;      // range * cum_high into the upper-bound divider
		logic mul_lo;      // range * cum_low into the lower-bound divider
		logic div_step;    // two quotient bits in both dividers
		logic bounds_upd;  // narrow the bounds from the quotients
		logic shift_emit;  // emit the matching top bit and shift both bounds
		logic e3_step;     // middle-half scaling step
		logic flush_emit;  // emit the top bit of the low bound and shift it
		logic clear_state; // return bounds and pending count to reset values
		logic cnt_clr;     // clear the step counter
		logic cnt_inc;     // advance the step counter
	} bae_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic tot_zero;    // captured total count is zero
		logic div_done;    // last divider step in progress
		logic top_match;   // both bounds agree on their top bit
		logic last_shift;  // this shift leaves the top bits different
		logic e3_ok;       // middle-half condition holds and steps remain
		logic flush_last;  // this flush bit is the last one
		logic can_emit;    // output register free or being drained
	} bae_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bae_in_if.sv =====
// Input channel of the encoder: one symbol interval or finish command per word.
// Depends on bae_pkg for the field widths.
`default_nettype none

interface bae_in_if;
	import bae_pkg::*;

	logic               valid;
	logic               ready;
	logic               cmd;
	logic [FIELD_W-1:0] cum_low;
	logic [FIELD_W-1:0] cum_high;
	logic [FIELD_W-1:0] total_count;

	modport source (output valid, cmd, cum_low, cum_high, total_count, input ready);
	modport sink   (input valid, cmd, cum_low, cum_high, total_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/bae_out_if.sv =====
// Output channel of the encoder: one code bit with its follow count per word.
// Depends on bae_pkg for the field widths.
`default_nettype none

interface bae_out_if;
	import bae_pkg::*;

	logic                valid;
	logic                ready;
	logic                out_bit;
	logic [FOLLOW_W-1:0] follow_count;
	logic                last;

	modport source (output valid, out_bit, follow_count, last, input ready);
	modport sink   (input valid, out_bit, follow_count, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/bae_ctrl.sv =====
// Controller state machine of the encoder: sequences multiply, divide,
// bound update, bit shifting, middle-half scaling and flush. Uses bae_pkg.
`default_nettype none

module bae_ctrl import bae_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      accept,
	input  wire logic      fin,
	input  wire bae_stat_t stat,
	output logic           idle,
	output bae_cmd_t       cmd
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MUL_HI = 8'b0000_0010,
		ST_MUL_LO = 8'b0000_0100,
		ST_DIV    = 8'b0000_1000,
		ST_UPDATE = 8'b0001_0000,
		ST_SHIFT  = 8'b0010_0000,
		ST_SCALE  = 8'b0100_0000,
		ST_FLUSH  = 8'b1000_0000
	} bae_state_t;

	bae_state_t state_q, state_d;

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.cnt_clr = 1'b1;
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = (fin == CMD_FINISH) ? ST_FLUSH : ST_MUL_HI;
				end
			end
			ST_MUL_HI: begin
				// drop an item with a zero total count
				if (stat.tot_zero) begin
					state_d = ST_IDLE;
				end else begin
					cmd.mul_hi = 1'b1;
					state_d    = ST_MUL_LO;
				end
			end
			ST_MUL_LO: begin
				cmd.mul_lo  = 1'b1;
				cmd.cnt_clr = 1'b1;
				state_d     = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.cnt_inc  = 1'b1;
				if (stat.div_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.bounds_upd = 1'b1;
				state_d        = ST_SHIFT;
			end
			ST_SHIFT: begin
				cmd.cnt_clr = 1'b1;
				if (!stat.top_match) begin
					state_d = ST_SCALE;
				end else if (stat.can_emit) begin
					cmd.shift_emit = 1'b1;
					if (stat.last_shift) begin
						state_d = ST_SCALE;
					end
				end
			end
			ST_SCALE: begin
				if (stat.e3_ok) begin
					cmd.e3_step = 1'b1;
					cmd.cnt_inc = 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (stat.can_emit) begin
					cmd.flush_emit = 1'b1;
					cmd.cnt_inc    = 1'b1;
					if (stat.flush_last) begin
						cmd.clear_state = 1'b1;
						state_d         = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign idle = (state_q == ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/bae_dp.sv =====
// Datapath of the encoder: bounds, pending count, shared multiplier, two
// radix-4 restoring dividers, step counter and output register. Uses bae_pkg.
`default_nettype none

module bae_dp import bae_pkg::*; #(
	parameter int PRECISION_BITS = PRECISION_DEF,
	parameter int COUNT_BITS     = COUNT_DEF,
	parameter int PENDING_BITS   = PENDING_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bae_cmd_t            cmd,
	output bae_stat_t                stat,
	input  wire logic [FIELD_W-1:0]  cum_low,
	input  wire logic [FIELD_W-1:0]  cum_high,
	input  wire logic [FIELD_W-1:0]  total_count,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output logic                     out_bit,
	output logic [FOLLOW_W-1:0]      follow_count,
	output logic                     out_last
);

	localparam int P       = PRECISION_BITS;
	localparam int C       = COUNT_BITS;
	localparam int PB      = PENDING_BITS;
	localparam int DW      = P + 1 + C;            // product width
	localparam int DIV_CYC = (DW + 1) / 2;         // two quotient bits a cycle
	localparam int DWP     = 2 * DIV_CYC;          // dividend padded to even
	localparam int MAXC    = (DIV_CYC > P) ? DIV_CYC : P;
	localparam int CNT_W   = $clog2(MAXC + 1);

	logic [P-1:0]     low_q, high_q;
	logic [PB-1:0]    pend_q;
	logic [C-1:0]     clo_q, chi_q, tot_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DWP-1:0]   dvd_q  [2];
	logic [C-1:0]     rem_q  [2];
	logic [P-1:0]     quo_q  [2];
	logic [DWP-1:0]   dvd_d  [2];
	logic [C-1:0]     rem_d  [2];
	logic [P-1:0]     quo_d  [2];

	logic [P:0]       range;
	logic [C-1:0]     mul_b;
	logic [DW-1:0]    prod;
	logic [FOLLOW_W-1:0] follow;
	logic             emit, e3_cond;

	// Capture the symbol interval of an accepted word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			clo_q <= cum_low[C-1:0];
			chi_q <= cum_high[C-1:0];
			tot_q <= total_count[C-1:0];
		end
	end

	// Width of the current interval, one more than the bound difference
	assign range = {1'b0, high_q} - {1'b0, low_q} + {{P{1'b0}}, 1'b1};

	// Shared multiplier, one operand per cycle
	assign mul_b = cmd.mul_hi ? chi_q : clo_q;
	assign prod  = {{C{1'b0}}, range} * {{(P+1){1'b0}}, mul_b};

	// Two restoring division steps per lane
	always_comb begin
		logic [C:0] trial;
		logic [C:0] diff;
		for (int l = 0; l < 2; l++) begin
			dvd_d[l] = dvd_q[l];
			rem_d[l] = rem_q[l];
			quo_d[l] = quo_q[l];
			for (int k = 0; k < 2; k++) begin
				trial    = {rem_d[l], dvd_d[l][DWP-1]};
				diff     = trial - {1'b0, tot_q};
				dvd_d[l] = {dvd_d[l][DWP-2:0], 1'b0};
				if (trial >= {1'b0, tot_q}) begin
					rem_d[l] = diff[C-1:0];
					quo_d[l] = {quo_d[l][P-2:0], 1'b1};
				end else begin
					rem_d[l] = trial[C-1:0];
					quo_d[l] = {quo_d[l][P-2:0], 1'b0};
				end
			end
		end
	end

	// Load dividends from the multiplier, then iterate both lanes
	always_ff @(posedge clk) begin
		if (cmd.mul_hi) begin
			dvd_q[0] <= DWP'(prod);
			rem_q[0] <= '0;
			quo_q[0] <= '0;
		end else if (cmd.div_step) begin
			dvd_q[0] <= dvd_d[0];
			rem_q[0] <= rem_d[0];
			quo_q[0] <= quo_d[0];
		end
		if (cmd.mul_lo) begin
			dvd_q[1] <= DWP'(prod);
			rem_q[1] <= '0;
			quo_q[1] <= '0;
		end else if (cmd.div_step) begin
			dvd_q[1] <= dvd_d[1];
			rem_q[1] <= rem_d[1];
			quo_q[1] <= quo_d[1];
		end
	end

	// Step counter for division, scaling and flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};
		end
	end

	// Bounds: narrow, shift out, scale the middle half, flush, clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '1;
		end else if (cmd.clear_state) begin
			low_q  <= '0;
			high_q <= '1;
		end else if (cmd.bounds_upd) begin
			high_q <= low_q + quo_q[0] - {{(P-1){1'b0}}, 1'b1};
			low_q  <= low_q + quo_q[1];
		end else if (cmd.shift_emit) begin
			low_q  <= {low_q[P-2:0], 1'b0};
			high_q <= {high_q[P-2:0], 1'b1};
		end else if (cmd.e3_step) begin
			low_q  <= {~low_q[P-2], low_q[P-3:0], 1'b0};
			high_q <= {~high_q[P-2], high_q[P-3:0], 1'b1};
		end else if (cmd.flush_emit) begin
			low_q  <= {low_q[P-2:0], 1'b0};
		end
	end

	// Pending opposite bits: hand over on emit, saturate on scaling
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (emit || cmd.clear_state) begin
			pend_q <= '0;
		end else if (cmd.e3_step && !(&pend_q)) begin
			pend_q <= pend_q + {{(PB-1){1'b0}}, 1'b1};
		end
	end

	// Clamp the pending count to the follow field
	generate
		if (PB > FOLLOW_W) begin : g_follow_sat
			assign follow = (|pend_q[PB-1:FOLLOW_W]) ? '1 : pend_q[FOLLOW_W-1:0];
		end else begin : g_follow_ext
			assign follow = FOLLOW_W'(pend_q);
		end
	endgenerate

	assign emit = cmd.shift_emit || cmd.flush_emit;

	// Output register, refilled while the previous word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_bit      <= low_q[P-1];
			follow_count <= follow;
			out_last     <= cmd.flush_emit ? stat.flush_last : stat.last_shift;
		end
	end

	// Status back to the controller
	assign e3_cond = low_q[P-2] && !high_q[P-2];

	always_comb begin
		stat            = '0;
		stat.tot_zero   = (tot_q == '0);
		stat.div_done   = (cnt_q == CNT_W'(DIV_CYC - 1));
		stat.top_match  = (low_q[P-1] == high_q[P-1]);
		stat.last_shift = (low_q[P-2] != high_q[P-2]);
		stat.e3_ok      = e3_cond && (cnt_q != CNT_W'(P));
		stat.flush_last = (cnt_q == CNT_W'(P - 1));
		stat.can_emit   = !out_valid || out_ready;
	end

endmodule

`default_nettype wire

// ===== rtl/binary_arithmetic_encoder.sv =====
// Top level of the binary arithmetic encoder: controller plus datapath.
// Depends on bae_pkg, bae_in_if, bae_out_if, bae_ctrl and bae_dp.
//
// Integer arithmetic encoder with E1/E2/E3 scaling. Each word on sym is
// either an encode (cmd 0: the symbol interval cum_low..cum_high out of
// total_count) or a finish (cmd 1). The block narrows its PRECISION_BITS
// bounds, then sends one word on code for every top bit the bounds share:
// the bit and the count of opposite bits to follow it; last marks the final
// word of an item, and an encode that shifts nothing yields no word at all.
// A finish sends PRECISION_BITS words of the low bound and resets the state.
// One item is taken at a time. An encode multiplies, runs the two radix-4
// dividers, narrows the bounds, then shifts out bits and takes middle-half
// steps. An item with a zero total count is dropped. Output stalls hold the
// block but never lose a word.
`default_nettype none

module binary_arithmetic_encoder import bae_pkg::*; #(
	parameter int PRECISION_BITS = PRECISION_DEF,
	parameter int COUNT_BITS     = COUNT_DEF,
	parameter int PENDING_BITS   = PENDING_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bae_in_if.sink    sym,
	bae_out_if.source code
);

	bae_cmd_t  cmd;
	bae_stat_t stat;
	logic      idle;
	logic      accept;

	// Take a word only while the controller is idle
	assign sym.ready = idle;
	assign accept    = sym.valid && idle;

	bae_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.fin    (sym.cmd),
		.stat   (stat),
		.idle   (idle),
		.cmd    (cmd)
	);

	bae_dp #(
		.PRECISION_BITS (PRECISION_BITS),
		.COUNT_BITS     (COUNT_BITS),
		.PENDING_BITS   (PENDING_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cum_low      (sym.cum_low),
		.cum_high     (sym.cum_high),
		.total_count  (sym.total_count),
		.out_ready    (code.ready),
		.out_valid    (code.valid),
		.out_bit      (code.out_bit),
		.follow_count (code.follow_count),
		.out_last     (code.last)
	);

endmodule

`default_nettype wire
